// ===== hdl/dpmb_pkg.sv =====
// ----------------------------------------------------------------------------
// Mailbox and semaphore register block package
// Access kinds, register offsets and byte-lane helpers for the shared
// application/modem register block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dpmb_pkg;

  // Bus access kind carried in the request user bits.
  typedef enum logic {
    CMD_READ  = 1'b0,
    CMD_WRITE = 1'b1
  } cmd_e;

  // Register byte offsets.
  localparam logic [7:0] OFF_SEM      = 8'h00;
  localparam logic [7:0] OFF_SEM_B1   = 8'h01;
  localparam logic [7:0] OFF_MBA      = 8'h20;
  localparam logic [7:0] OFF_MBA_B1   = 8'h21;
  localparam logic [7:0] OFF_MBA_B2   = 8'h22;
  localparam logic [7:0] OFF_MBA_B3   = 8'h23;
  localparam logic [7:0] OFF_MBM      = 8'h40;
  localparam logic [7:0] OFF_MBM_B1   = 8'h41;
  localparam logic [7:0] OFF_UNA      = 8'hA0;
  localparam logic [7:0] OFF_UNA_B1   = 8'hA1;
  localparam logic [7:0] OFF_UNM      = 8'hC0;
  localparam logic [7:0] OFF_UNM_B1   = 8'hC1;

  localparam logic [31:0] LOW_BYTE_MASK  = 32'h0000_00FF;
  localparam logic [31:0] HIGH_BYTE_MASK = 32'h0000_FF00;

  // Returns one byte lane of a word, zero-extended.
  function automatic logic [31:0] byte_sel(input logic [31:0] word,
                                           input logic [1:0]  idx);
    logic [31:0] shifted;
    shifted = word >> {idx, 3'b000};
    return shifted & LOW_BYTE_MASK;
  endfunction

endpackage

// ===== hdl/dual_port_mailbox_semaphore_regs.sv =====
// ----------------------------------------------------------------------------
// Dual-port mailbox and semaphore registers
// Pipeline: a request sits in the input register, then decode and update
// load the response register once it is empty or being drained.
// Throughput: one request per cycle while the consumer takes responses;
// nothing in the datapath iterates.
// Reset: rst_ni clears the register state, both pending bits and both
// valids; the request and response payload registers are not reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dual_port_mailbox_semaphore_regs
  import dpmb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Request channel.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [7:0] reg_offset, [39:8] write_data
  input  logic [1:0]  s_axis_tuser,   // [0] cmd, [1] byte_access
  // Response channel.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] read_data, [32] app_irq,
                                      // [33] modem_irq, [39:34] zero
  output logic        m_axis_tuser    // [0] bad_offset
);

  // --------------------------------------------------------------------------
  // Input register. It is free to load when empty or when its contents move on
  // into the response register in the same cycle, so requests stream at full rate while responses drain.
  // --------------------------------------------------------------------------
  logic        in_valid_q;
  cmd_e        in_cmd_q;
  logic        in_byte_q;
  logic [7:0]  in_off_q;
  logic [31:0] in_wdata_q;

  logic        out_valid_q;
  logic [31:0] out_rdata_q;
  logic        out_app_irq_q;
  logic        out_modem_irq_q;
  logic        out_bad_q;

  // The request in the input register is processed when the response
  // register is empty or is being drained this cycle.
  logic advance;
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_cmd_q   <= cmd_e'(s_axis_tuser[0]);
      in_byte_q  <= s_axis_tuser[1];
      in_off_q   <= s_axis_tdata[7:0];
      in_wdata_q <= s_axis_tdata[39:8];
    end
  end

  // --------------------------------------------------------------------------
  // Architectural state.
  // --------------------------------------------------------------------------
  logic [31:0] sem_q, sem_d;
  logic [31:0] mba_q, mba_d;       // mailbox toward the application side
  logic [31:0] mbm_q, mbm_d;       // mailbox toward the modem side
  logic [31:0] una_q, una_d;       // unread word of the application mailbox
  logic [31:0] unm_q, unm_d;       // unread word of the modem mailbox
  logic        app_pend_q, app_pend_d;
  logic        modem_pend_q, modem_pend_d;

  logic        ok;
  logic [31:0] rdata;
  logic [31:0] lo_byte;
  logic [31:0] hi_byte;

  assign lo_byte = in_wdata_q & LOW_BYTE_MASK;
  assign hi_byte = {in_wdata_q[23:0], 8'h00} & HIGH_BYTE_MASK;

  // --------------------------------------------------------------------------
  // Decode and update. A word write to a mailbox, or a byte write to its byte 1,
  // raises the receiver's interrupt; a read of the mailbox word or of its odd
  // bytes acknowledges it. Undefined offsets leave all state alone, read
  // as zero and flag the response.
  // --------------------------------------------------------------------------
  always_comb begin
    sem_d        = sem_q;
    mba_d        = mba_q;
    mbm_d        = mbm_q;
    una_d        = una_q;
    unm_d        = unm_q;
    app_pend_d   = app_pend_q;
    modem_pend_d = modem_pend_q;
    ok           = 1'b1;
    rdata        = '0;

    if (in_cmd_q == CMD_WRITE) begin
      if (!in_byte_q) begin
        case (in_off_q)
          OFF_SEM: sem_d = in_wdata_q;
          OFF_MBA: begin
            mba_d      = in_wdata_q;
            una_d      = 32'd1;
            app_pend_d = 1'b1;
          end
          OFF_MBM: begin
            mbm_d        = in_wdata_q;
            unm_d        = 32'd1;
            modem_pend_d = 1'b1;
          end
          OFF_UNA: una_d = in_wdata_q;
          OFF_UNM: unm_d = in_wdata_q;
          default: ok = 1'b0;
        endcase
      end else begin
        case (in_off_q)
          OFF_SEM: sem_d = lo_byte;
          OFF_MBA: mba_d = lo_byte;
          OFF_MBA_B1: begin
            mba_d      = mba_q | hi_byte;
            una_d      = 32'd1;
            app_pend_d = 1'b1;
          end
          OFF_MBM: mbm_d = lo_byte;
          OFF_MBM_B1: begin
            mbm_d        = mbm_q | hi_byte;
            unm_d        = 32'd1;
            modem_pend_d = 1'b1;
          end
          OFF_UNA:    una_d = lo_byte;
          OFF_UNA_B1: una_d = una_q | hi_byte;
          OFF_UNM:    unm_d = lo_byte;
          OFF_UNM_B1: unm_d = unm_q | hi_byte;
          default:    ok = 1'b0;
        endcase
      end
    end else begin
      if (!in_byte_q) begin
        case (in_off_q)
          OFF_SEM: rdata = sem_q;
          OFF_MBA: begin
            rdata      = mba_q;
            una_d      = '0;
            app_pend_d = 1'b0;
          end
          OFF_MBM: begin
            rdata        = mbm_q;
            unm_d        = '0;
            modem_pend_d = 1'b0;
          end
          OFF_UNA: rdata = una_q;
          OFF_UNM: rdata = unm_q;
          default: ok = 1'b0;
        endcase
      end else begin
        case (in_off_q)
          OFF_SEM, OFF_SEM_B1: rdata = byte_sel(sem_q, in_off_q[1:0]);
          OFF_MBA, OFF_MBA_B2: rdata = byte_sel(mba_q, in_off_q[1:0]);
          OFF_MBA_B1, OFF_MBA_B3: begin
            rdata      = byte_sel(mba_q, in_off_q[1:0]);
            una_d      = '0;
            app_pend_d = 1'b0;
          end
          OFF_MBM: rdata = byte_sel(mbm_q, in_off_q[1:0]);
          OFF_MBM_B1: begin
            rdata        = byte_sel(mbm_q, in_off_q[1:0]);
            unm_d        = '0;
            modem_pend_d = 1'b0;
          end
          OFF_UNA, OFF_UNA_B1: rdata = byte_sel(una_q, in_off_q[1:0]);
          OFF_UNM, OFF_UNM_B1: rdata = byte_sel(unm_q, in_off_q[1:0]);
          default:             ok = 1'b0;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sem_q        <= '0;
      mba_q        <= '0;
      mbm_q        <= '0;
      una_q        <= '0;
      unm_q        <= '0;
      app_pend_q   <= 1'b0;
      modem_pend_q <= 1'b0;
    end else if (advance) begin
      sem_q        <= sem_d;
      mba_q        <= mba_d;
      mbm_q        <= mbm_d;
      una_q        <= una_d;
      unm_q        <= unm_d;
      app_pend_q   <= app_pend_d;
      modem_pend_q <= modem_pend_d;
    end
  end

  // --------------------------------------------------------------------------
  // Response register. It holds a finished response while the consumer
  // stalls; the interrupt levels it carries are those after the request.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_rdata_q     <= rdata;
      out_app_irq_q   <= app_pend_d;
      out_modem_irq_q <= modem_pend_d;
      out_bad_q       <= !ok;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b000000, out_modem_irq_q, out_app_irq_q, out_rdata_q};
  assign m_axis_tuser  = out_bad_q;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  a_word_write_raises_app: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (in_cmd_q == CMD_WRITE) && !in_byte_q && (in_off_q == OFF_MBA)
    |=> app_pend_q && (una_q == 32'd1))
    else $error("word write to application mailbox did not raise its interrupt");

  a_word_read_clears_modem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (in_cmd_q == CMD_READ) && !in_byte_q && (in_off_q == OFF_MBM)
    |=> !modem_pend_q && (unm_q == '0) && !out_modem_irq_q)
    else $error("word read of modem mailbox did not acknowledge it");

  a_bad_offset_response: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && !ok |=> out_valid_q && out_bad_q && (out_rdata_q == '0))
    else $error("undefined offset did not give a flagged zero response");

  a_bad_offset_no_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && !ok |=> $stable(sem_q) && $stable(mba_q) && $stable(mbm_q)
                      && $stable(una_q) && $stable(unm_q)
                      && $stable(app_pend_q) && $stable(modem_pend_q))
    else $error("undefined offset changed register state");

endmodule
